### design/thtrig_pkg.sv
// Package: shared types and codes for the timed hysteresis trigger.
`default_nettype none
package thtrig_pkg;

  typedef enum logic [1:0] {
    FUNC_UPDATE     = 2'd0,
    FUNC_FORCE_HIGH = 2'd1,
    FUNC_FORCE_LOW  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_FALLING_THRESHOLD = 2'd0,
    REG_RISING_THRESHOLD  = 2'd1,
    REG_FALLING_DELAY     = 2'd2,
    REG_RISING_DELAY      = 2'd3
  } reg_idx_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned LEVEL_W    = 32;

  typedef struct packed {
    logic [1:0]                sample_func;
    logic [TIME_W-1:0]         sample_time;
    logic signed [LEVEL_W-1:0] sample_level;
  } item_t;

  typedef struct packed {
    logic                      trigger_state;
    logic signed [LEVEL_W-1:0] last_level;
    logic                      time_went_back;
  } result_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] falling_threshold;
    logic signed [LEVEL_W-1:0] rising_threshold;
    logic [CFG_DATA_W-1:0]     falling_delay;
    logic [CFG_DATA_W-1:0]     rising_delay;
  } cfg_t;

  typedef struct packed {
    logic output_high;
    logic awaiting_first;
  } status_t;

endpackage
`default_nettype wire

### design/thtrig_if.sv
// Interfaces: valid/ready channels for sample items and result items.
`default_nettype none
interface thtrig_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] sample_time;
  logic signed [31:0] sample_level;

  modport source (output valid, output func, output sample_time, output sample_level,
                  input ready);
  modport sink (input valid, input func, input sample_time, input sample_level,
                output ready);
endinterface

interface thtrig_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_state;
  logic signed [31:0] last_level;
  logic        time_went_back;

  modport source (output valid, output trigger_state, output last_level,
                  output time_went_back, input ready);
  modport sink (input valid, input trigger_state, input last_level,
                input time_went_back, output ready);
endinterface
`default_nettype wire

### design/thtrig_core.sv
// Core: trigger state, dwell timer and per-item update logic.
`default_nettype none
module thtrig_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clear,
  input  wire logic                step,
  input  wire thtrig_pkg::item_t   item,
  input  wire thtrig_pkg::cfg_t    cfg,
  output thtrig_pkg::result_t      result,
  output thtrig_pkg::status_t      status
);

  logic                                  output_high;
  logic                                  output_high_next;
  logic [thtrig_pkg::TIME_W-1:0]         dwell_timer;
  logic [thtrig_pkg::TIME_W-1:0]         dwell_timer_next;
  logic [thtrig_pkg::TIME_W-1:0]         previous_stamp;
  logic [thtrig_pkg::TIME_W-1:0]         previous_stamp_next;
  logic signed [thtrig_pkg::LEVEL_W-1:0] held_level;
  logic signed [thtrig_pkg::LEVEL_W-1:0] held_level_next;
  logic                                  awaiting_first;
  logic                                  awaiting_first_next;

  logic [thtrig_pkg::TIME_W-1:0] prev_eff;
  logic [thtrig_pkg::TIME_W-1:0] delta;
  logic [thtrig_pkg::TIME_W:0]   sum;
  logic [thtrig_pkg::TIME_W-1:0] timer_sat;
  logic                          went_back;
  logic                          in_zone;
  logic [thtrig_pkg::TIME_W-1:0] limit;

  always_comb begin
    prev_eff  = awaiting_first ? item.sample_time : previous_stamp;
    went_back = item.sample_time < prev_eff;
    delta     = item.sample_time - prev_eff;
    sum       = {1'b0, dwell_timer} + {1'b0, delta};
    timer_sat = sum[thtrig_pkg::TIME_W] ? '1 : sum[thtrig_pkg::TIME_W-1:0];
    if (output_high) begin
      in_zone = item.sample_level <= cfg.falling_threshold;
      limit   = {{(thtrig_pkg::TIME_W-thtrig_pkg::CFG_DATA_W){1'b0}}, cfg.falling_delay};
    end else begin
      in_zone = item.sample_level >= cfg.rising_threshold;
      limit   = {{(thtrig_pkg::TIME_W-thtrig_pkg::CFG_DATA_W){1'b0}}, cfg.rising_delay};
    end
  end

  always_comb begin
    output_high_next    = output_high;
    dwell_timer_next    = dwell_timer;
    previous_stamp_next = previous_stamp;
    held_level_next     = held_level;
    awaiting_first_next = awaiting_first;
    case (thtrig_pkg::func_t'(item.sample_func))
      thtrig_pkg::FUNC_FORCE_HIGH: begin
        output_high_next = 1'b1;
        dwell_timer_next = '0;
      end
      thtrig_pkg::FUNC_FORCE_LOW: begin
        output_high_next = 1'b0;
        dwell_timer_next = '0;
      end
      thtrig_pkg::FUNC_UPDATE: begin
        awaiting_first_next = 1'b0;
        if (awaiting_first) begin
          previous_stamp_next = item.sample_time;
        end
        if (!went_back) begin
          held_level_next     = item.sample_level;
          previous_stamp_next = item.sample_time;
          if (!in_zone) begin
            dwell_timer_next = '0;
          end else if (dwell_timer > limit) begin
            output_high_next = !output_high;
          end else begin
            dwell_timer_next = timer_sat;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.trigger_state  = output_high_next;
    result.last_level     = held_level_next;
    result.time_went_back =
      (thtrig_pkg::func_t'(item.sample_func) == thtrig_pkg::FUNC_UPDATE) && went_back;
    status.output_high    = output_high;
    status.awaiting_first = awaiting_first;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      output_high    <= 1'b0;
      dwell_timer    <= '0;
      previous_stamp <= '0;
      held_level     <= '0;
      awaiting_first <= 1'b1;
    end else if (step) begin
      output_high    <= output_high_next;
      dwell_timer    <= dwell_timer_next;
      previous_stamp <= previous_stamp_next;
      held_level     <= held_level_next;
      awaiting_first <= awaiting_first_next;
    end
  end

endmodule
`default_nettype wire

### design/timed_hysteresis_trigger.sv
// Top level: input register, config registers, trigger core and result register.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless results stall; core steps once per item.
// Reset: rst clears the config registers to zero, empties both stages and
// returns the trigger to low with the first-sample flag set.
// A config write also clears the trigger state.
`default_nettype none
module timed_hysteresis_trigger (
  input  wire logic                               clk,
  input  wire logic                               rst,
  thtrig_in_if.sink                               samples,
  thtrig_out_if.source                            results,
  input  wire logic                               cfg_we,
  input  wire logic [thtrig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [thtrig_pkg::CFG_DATA_W-1:0]  cfg_data
);

  thtrig_pkg::cfg_t    cfg;
  thtrig_pkg::item_t   s1_item;
  logic                s1_valid;
  logic                advance;
  thtrig_pkg::result_t core_result;
  thtrig_pkg::status_t status;
  thtrig_pkg::result_t out_item;
  logic                out_valid;

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (thtrig_pkg::reg_idx_t'(cfg_index))
        thtrig_pkg::REG_FALLING_THRESHOLD: cfg.falling_threshold <= cfg_data;
        thtrig_pkg::REG_RISING_THRESHOLD:  cfg.rising_threshold  <= cfg_data;
        thtrig_pkg::REG_FALLING_DELAY:     cfg.falling_delay     <= cfg_data;
        thtrig_pkg::REG_RISING_DELAY:      cfg.rising_delay      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item.sample_func  <= samples.func;
      s1_item.sample_time  <= samples.sample_time;
      s1_item.sample_level <= samples.sample_level;
    end
  end

  thtrig_core u_core (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_we),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign results.valid          = out_valid;
  assign results.trigger_state  = out_item.trigger_state;
  assign results.last_level     = out_item.last_level;
  assign results.time_went_back = out_item.time_went_back;

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (!status.output_high && status.awaiting_first))
    else $error("config write did not clear trigger state");

  a_force_high: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg_we && s1_item.sample_func == thtrig_pkg::FUNC_FORCE_HIGH)
      |=> (status.output_high && results.valid && results.trigger_state))
    else $error("force high not reflected in state and result");

  a_force_low: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg_we && s1_item.sample_func == thtrig_pkg::FUNC_FORCE_LOW)
      |=> (!status.output_high && results.valid && !results.trigger_state))
    else $error("force low not reflected in state and result");

endmodule
`default_nettype wire
